>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL; they sample on clk_i and
// stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a condition at every rising clock edge.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/bgct_pkg.sv
package bgct_pkg;

  // Timing constants
  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned SECOND_MS     = 1000;

  // Register widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values
  localparam logic [9:0]  DEBOUNCE_RST     = 10'd50;
  localparam logic [11:0] SHORT_PRESS_RST  = 12'd400;
  localparam logic [11:0] CLICK_WINDOW_RST = 12'd400;
  localparam logic [11:0] REFRESH_GAP_RST  = 12'd300;
  localparam logic [23:0] IDLE_TIMEOUT_RST = 24'd660000;
  localparam logic [3:0]  MAX_MINUTES_RST  = 4'd9;

  // State reset values
  localparam logic [31:0] WAKE_DEADLINE_RST = 32'd5000;
  localparam logic [1:0]  WAKE_EDGES_AWAKE  = 2'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_SHORT_PRESS  = 3'd1,
    CFG_CLICK_WINDOW = 3'd2,
    CFG_REFRESH_GAP  = 3'd3,
    CFG_IDLE_TIMEOUT = 3'd4,
    CFG_MAX_MINUTES  = 3'd5
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    logic kind;
    logic pin_level;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [3:0]  minutes_chosen;
    logic        counting;
    logic [19:0] remaining_ms;
    logic        refresh;
    logic        expired;
    logic        sleep_request;
  } out_word_t;

  // Add two times, clamp at the top of the range
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Countdown length of a minute count in milliseconds
  function automatic logic [31:0] minute_ms(input logic [3:0] m);
    logic [35:0] prod;
    prod = 36'(MS_PER_MINUTE) * {32'd0, m};
    return prod[31:0];
  endfunction

endpackage

>>> hdl/button_gesture_countdown_timer.sv
// One-button countdown timer controller.
// Input channel (in_valid_i / in_stall_o / in_data_i): one word per event,
// kind 0 is a millisecond tick, kind 1 a button pin edge with its level.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one word
// per input word, in order: chosen minutes, countdown state, ms left, and
// refresh / expired / sleep_request strobes (strobes are 0 for edge words).
// Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// always ready; write only while no word is in flight. Unknown indexes
// are dropped.
// A word goes through one input register and then one result register.
// Throughput: one word per cycle while the receiver does not stall; the
// whole state update for a word is one pass of compare and add logic
// between the input and result registers.
// When the receiver stalls, the result register holds its word, the input
// register holds the next one, and in_stall_o rises while both are full.
// Reset (rst_ni low, asynchronous): registers go to their defaults, the
// timer is awake, idle and set to one minute; both stages empty.
module button_gesture_countdown_timer
  import bgct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  // Configuration registers
  logic [9:0]  debounce_q;
  logic [11:0] short_press_q, click_window_q, refresh_gap_q;
  logic [23:0] idle_timeout_q;
  logic [3:0]  max_minutes_q;

  // Pipeline registers
  logic      in_valid_q, in_valid_d;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;
  logic      load_out, proc, in_take;

  // Controller state
  logic [31:0] now_q, now_d;
  logic [31:0] wake_deadline_q, wake_deadline_d;
  logic [1:0]  wake_edges_q, wake_edges_d;
  logic        held_q, held_d;
  logic [31:0] press_time_q, press_time_d;
  logic [31:0] debounce_time_q, debounce_time_d;
  logic [7:0]  click_count_q, click_count_d;
  logic        click_pending_q, click_pending_d;
  logic [31:0] click_deadline_q, click_deadline_d;
  logic        running_q, running_d;
  logic [31:0] countdown_deadline_q, countdown_deadline_d;
  logic [31:0] second_mark_q, second_mark_d;
  logic        redraw_pending_q, redraw_pending_d;
  logic [31:0] redraw_guard_q, redraw_guard_d;
  logic [3:0]  minutes_q, minutes_d;

  // Shared intermediate values
  logic        press_now, held_mid;
  logic [31:0] press_mid, press_len, now_inc, left_ms;
  logic [7:0]  click_next;
  logic        refresh_s, expired_s, sleep_s;

  // Handshake: the result register frees up when empty or being taken
  assign load_out    = !out_valid_q || !out_stall_i;
  assign proc        = in_valid_q && load_out;
  assign in_stall_o  = in_valid_q && !load_out;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  // Press registration and press length on an edge
  assign press_now  = !held_q && ((now_q - debounce_time_q) >= {22'd0, debounce_q});
  assign held_mid   = held_q || press_now;
  assign press_mid  = press_now ? now_q : press_time_q;
  assign press_len  = now_q - press_mid;
  assign click_next = (click_count_q != 8'hFF) ? click_count_q + 8'd1 : click_count_q;
  assign now_inc    = sat_add(now_q, 32'd1);

  // Advance the state by one word
  always_comb begin
    now_d                = now_q;
    wake_deadline_d      = wake_deadline_q;
    wake_edges_d         = wake_edges_q;
    held_d               = held_q;
    press_time_d         = press_time_q;
    debounce_time_d      = debounce_time_q;
    click_count_d        = click_count_q;
    click_pending_d      = click_pending_q;
    click_deadline_d     = click_deadline_q;
    running_d            = running_q;
    countdown_deadline_d = countdown_deadline_q;
    second_mark_d        = second_mark_q;
    redraw_pending_d     = redraw_pending_q;
    redraw_guard_d       = redraw_guard_q;
    minutes_d            = minutes_q;
    refresh_s            = 1'b0;
    expired_s            = 1'b0;
    sleep_s              = 1'b0;
    left_ms              = 32'd0;

    if (in_word_q.kind) begin
      // Pin edge: push out the idle deadline, ask for a redraw
      wake_deadline_d  = sat_add(now_q, {8'd0, idle_timeout_q});
      redraw_pending_d = 1'b1;
      if (wake_edges_q < WAKE_EDGES_AWAKE) begin
        // Swallow edges while waking up
        wake_edges_d = wake_edges_q + 2'd1;
      end else begin
        held_d = held_mid;
        if (press_now) begin
          press_time_d    = now_q;
          debounce_time_d = now_q;
        end
        if (in_word_q.pin_level && held_mid && (press_mid != now_q)) begin
          held_d = 1'b0;
          // Short press: count a click, open the window on the first one
          if (press_len < {20'd0, short_press_q}) begin
            click_count_d = click_next;
            if (click_next < 8'd2) begin
              click_deadline_d = sat_add(now_q, {20'd0, click_window_q});
            end
            click_pending_d = 1'b1;
          end
          // Long press: start or stop the countdown
          if (press_len > {20'd0, short_press_q}) begin
            if (!running_q) begin
              running_d            = 1'b1;
              countdown_deadline_d = sat_add(now_q, minute_ms(minutes_q));
            end else begin
              running_d = 1'b0;
            end
          end
        end
      end
    end else begin
      now_d = now_inc;

      // Close the click window and adjust the minutes
      if (click_pending_q && !running_q && (now_inc >= click_deadline_q)) begin
        if ((click_count_q == 8'd1) && (minutes_q < max_minutes_q)) begin
          minutes_d = minutes_q + 4'd1;
        end
        if ((click_count_q > 8'd1) && (minutes_q > 4'd1)) begin
          minutes_d = minutes_q - 4'd1;
        end
        click_pending_d  = 1'b0;
        click_count_d    = 8'd0;
        redraw_pending_d = 1'b1;
      end

      // Once-a-second countdown check
      if (running_q && (now_inc >= second_mark_q)) begin
        if (now_inc >= countdown_deadline_q) begin
          expired_s = 1'b1;
          running_d = 1'b0;
        end
        second_mark_d    = sat_add(now_inc, 32'(SECOND_MS));
        redraw_pending_d = 1'b1;
      end

      // Idle timeout: request sleep once
      if ((wake_deadline_q <= now_inc) && (wake_edges_q != 2'd0)) begin
        sleep_s      = 1'b1;
        wake_edges_d = 2'd0;
      end

      // Rate-limited refresh strobe
      if (redraw_pending_d && (redraw_guard_q < now_inc)) begin
        redraw_guard_d   = sat_add(now_inc, {20'd0, refresh_gap_q});
        redraw_pending_d = 1'b0;
        refresh_s        = 1'b1;
      end
    end

    // Time left, clamped to the field
    if (running_d && (countdown_deadline_d > now_d)) begin
      left_ms = countdown_deadline_d - now_d;
    end

    out_word_d.minutes_chosen = minutes_d;
    out_word_d.counting       = running_d;
    out_word_d.remaining_ms   = (left_ms > 32'h000F_FFFF) ? 20'hF_FFFF : left_ms[19:0];
    out_word_d.refresh        = refresh_s;
    out_word_d.expired        = expired_s;
    out_word_d.sleep_request  = sleep_s;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DEBOUNCE_RST;
      short_press_q  <= SHORT_PRESS_RST;
      click_window_q <= CLICK_WINDOW_RST;
      refresh_gap_q  <= REFRESH_GAP_RST;
      idle_timeout_q <= IDLE_TIMEOUT_RST;
      max_minutes_q  <= MAX_MINUTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:     debounce_q     <= cfg_data_i[9:0];
        CFG_SHORT_PRESS:  short_press_q  <= cfg_data_i[11:0];
        CFG_CLICK_WINDOW: click_window_q <= cfg_data_i[11:0];
        CFG_REFRESH_GAP:  refresh_gap_q  <= cfg_data_i[11:0];
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i[23:0];
        CFG_MAX_MINUTES:  max_minutes_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (load_out) begin
        out_valid_q <= proc;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_data_i;
    end
    if (proc) begin
      out_word_q <= out_word_d;
    end
  end

  // Controller state, committed when a word is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q                <= 32'd0;
      wake_deadline_q      <= WAKE_DEADLINE_RST;
      wake_edges_q         <= WAKE_EDGES_AWAKE;
      held_q               <= 1'b0;
      press_time_q         <= 32'd0;
      debounce_time_q      <= 32'd0;
      click_count_q        <= 8'd0;
      click_pending_q      <= 1'b0;
      click_deadline_q     <= 32'd0;
      running_q            <= 1'b0;
      countdown_deadline_q <= 32'd0;
      second_mark_q        <= 32'd0;
      redraw_pending_q     <= 1'b0;
      redraw_guard_q       <= 32'd0;
      minutes_q            <= 4'd1;
    end else if (proc) begin
      now_q                <= now_d;
      wake_deadline_q      <= wake_deadline_d;
      wake_edges_q         <= wake_edges_d;
      held_q               <= held_d;
      press_time_q         <= press_time_d;
      debounce_time_q      <= debounce_time_d;
      click_count_q        <= click_count_d;
      click_pending_q      <= click_pending_d;
      click_deadline_q     <= click_deadline_d;
      running_q            <= running_d;
      countdown_deadline_q <= countdown_deadline_d;
      second_mark_q        <= second_mark_d;
      redraw_pending_q     <= redraw_pending_d;
      redraw_guard_q       <= redraw_guard_d;
      minutes_q            <= minutes_d;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_minutes_nonzero, minutes_q != 4'd0)
  `ASSERT_ALWAYS(a_wake_edges_range, wake_edges_q <= WAKE_EDGES_AWAKE)
  `ASSERT_ALWAYS(a_idle_no_time_left, !out_valid_q || out_word_q.counting || (out_word_q.remaining_ms == 20'd0))
  `ASSERT_ALWAYS(a_expired_stops, !out_valid_q || !out_word_q.expired || !out_word_q.counting)
  `ASSERT_NEXT(a_edge_no_strobes, proc && in_word_q.kind, out_valid_q && !out_word_q.refresh && !out_word_q.expired && !out_word_q.sleep_request)
  `ASSERT_ALWAYS(a_stall_only_when_full, !in_stall_o || (out_valid_q && out_stall_i))

endmodule
